// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the stereo feedback delay.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define SFD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked on every edge, reset included.
`define SFD_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sfd_pkg.sv -----
// Shared types and constants of the stereo feedback delay.
// Depends on nothing; used by sfd_lane and stereo_feedback_delay.
package sfd_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Q1.15 gains.
    localparam int Q_SHIFT = 15;
    localparam int FB_MAX  = 31129;
    localparam int MIX_ONE = 32768;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 2'd0,
        REG_FEEDBACK = 2'd1,
        REG_WET_MIX  = 2'd2
    } t_cfg_reg;

    // Pipeline control handed to each lane.
    typedef struct packed {
        logic accept;   // request taken, issue the line read
        logic adv1;     // stage 1 moves to stage 2
        logic adv2;     // stage 2 writes back and leaves
    } t_lane_ctl;

endpackage

// ----- rtl/sfd_lane.sv -----
// One channel of the delay: its circular line memory, the feedback and blend products
// and the saturated write back. Depends on sfd_pkg.
module sfd_lane #(
    parameter int DEPTH       = 131072,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  sfd_pkg::t_lane_ctl                  i_ctl,
    input  logic [$clog2(DEPTH)-1:0]            i_rd_addr,
    input  logic                                i_rd_ok,
    input  logic [$clog2(DEPTH)-1:0]            i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]       i_x,
    input  logic [14:0]                         i_fb,
    input  logic [16:0]                         i_dry,
    input  logic [15:0]                         i_wet,
    output logic signed [SAMPLE_BITS+18:0]      o_mix
);

    localparam int AW = $clog2(DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam int LW = SB + 17;

    // Line memory; entries never written are masked by i_rd_ok.
    logic [SB-1:0] r_line [DEPTH];

    logic [SB-1:0]          r_rd;
    logic                   r_ok1;
    logic signed [SB-1:0]   r_x1;
    logic signed [SB-1:0]   r_x2;
    logic signed [SB+15:0]  r_pfb;
    logic signed [SB+17:0]  r_pdry;
    logic signed [SB+17:0]  r_pwet;

    logic signed [SB-1:0]   w_d;
    logic signed [SB+15:0]  n_pfb;
    logic signed [SB+17:0]  n_pdry;
    logic signed [SB+17:0]  n_pwet;
    logic signed [LW-1:0]   w_sum;
    logic                   w_fits;
    logic [SB-1:0]          w_line;

    // Stage 1: delayed sample and the three products.
    assign w_d    = r_ok1 ? $signed(r_rd) : '0;
    assign n_pfb  = w_d * $signed({1'b0, i_fb});
    assign n_pdry = r_x1 * $signed({1'b0, i_dry});
    assign n_pwet = w_d * $signed({1'b0, i_wet});

    // Stage 2: input plus scaled feedback, saturated to the sample range.
    assign w_sum  = r_x2 + (r_pfb >>> sfd_pkg::Q_SHIFT);
    assign w_fits = (&w_sum[LW-1:SB-1]) || !(|w_sum[LW-1:SB-1]);
    assign w_line = w_fits ? w_sum[SB-1:0]
                  : (w_sum[LW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});

    // Dry and wet parts of the blend, before saturation in the merge stage.
    assign o_mix = (r_pdry + r_pwet) >>> sfd_pkg::Q_SHIFT;

    // Memory port: read at request, write back when stage 2 leaves.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_rd  <= r_line[i_rd_addr];
            r_ok1 <= i_rd_ok;
            r_x1  <= i_x;
        end
        if (i_ctl.adv2) begin
            r_line[i_wr_addr] <= w_line;
        end
    end

    // Product registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r_x2   <= r_x1;
            r_pfb  <= n_pfb;
            r_pdry <= n_pdry;
            r_pwet <= n_pwet;
        end
    end

    // The address width must cover the line.
    logic [AW:0] w_depth_chk;
    assign w_depth_chk = (AW+1)'(DEPTH);

endmodule

// ----- rtl/sfd_merge.sv -----
// Merge stage: saturates both lane blends and holds them in the output register.
// Depends on nothing; its load comes from the top level.
module sfd_merge #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic                            i_out_ready,
    input  logic signed [SAMPLE_BITS+18:0]  i_left_mix,
    input  logic signed [SAMPLE_BITS+18:0]  i_right_mix,
    output logic                            o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]   o_left_out,
    output logic signed [SAMPLE_BITS-1:0]   o_right_out,
    output logic                            o_free
);

    localparam int SB = SAMPLE_BITS;
    localparam int MW = SB + 19;

    logic                 r_valid;
    logic [SB-1:0]        r_left;
    logic [SB-1:0]        r_right;
    logic                 w_lfit;
    logic                 w_rfit;
    logic [SB-1:0]        n_left;
    logic [SB-1:0]        n_right;

    // Clip each blend to the signed sample range.
    assign w_lfit  = (&i_left_mix[MW-1:SB-1]) || !(|i_left_mix[MW-1:SB-1]);
    assign w_rfit  = (&i_right_mix[MW-1:SB-1]) || !(|i_right_mix[MW-1:SB-1]);
    assign n_left  = w_lfit ? i_left_mix[SB-1:0]
                   : (i_left_mix[MW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});
    assign n_right = w_rfit ? i_right_mix[SB-1:0]
                   : (i_right_mix[MW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});

    // Output register is free when empty or being taken this cycle.
    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_left_out  = $signed(r_left);
    assign o_right_out = $signed(r_right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

endmodule

// ----- rtl/stereo_feedback_delay.sv -----
// Stereo feedback delay (echo): configuration registers, write pointer, pipeline control,
// two channel lanes and the output merge. Depends on sfd_pkg, sfd_lane, sfd_merge.
//
// Usage: a request on the input channel (i_in_valid / o_in_ready) carries one stereo
// sample pair. Each pair gives exactly one result on the output channel
// (o_out_valid / i_out_ready) with the dry/wet blend of both channels.
// Configuration writes (i_cfg_valid / o_cfg_ready, index and data) are always taken and
// are meant to happen while no request is in flight.
// Path: an accepted request passes the line read, the products and the write back into
// the output register before o_out_valid rises.
// Throughput: one request per cycle while the delay is three samples or more and the
// output is not stalled. With a delay of one or two samples a request waits until the
// request whose line entry it reads has written that entry back; this loop through the
// line memory then sets the rate.
// Reset: synchronous, active low; clears the pointer, the pipeline and the registers
// (delay one, no feedback, dry only). The lines read as zero until written, through a
// fill flag, so no clearing pass is needed and requests are taken right after reset.
// Stall: when the receiver holds i_out_ready low the output register keeps its result,
// the stages behind it fill up and o_in_ready falls once they are full.
`include "assert_macros.svh"

module stereo_feedback_delay #(
    parameter int DEPTH       = 131072,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]        i_right_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]        o_left_out,
    output logic signed [SAMPLE_BITS-1:0]        o_right_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam int CW = (AW > sfd_pkg::CFG_DATA_W) ? AW : sfd_pkg::CFG_DATA_W;
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

    // Clamped configuration.
    logic [AW-1:0]  r_delay;
    logic [14:0]    r_fb;
    logic [15:0]    r_wet;
    logic [16:0]    r_dry;

    // Write pointer and fill flag.
    logic [AW-1:0]  r_wr;
    logic           r_wrapped;

    // Pipeline occupancy and write addresses in flight.
    logic           r_s1_valid;
    logic           r_s2_valid;
    logic [AW-1:0]  r_wr1;
    logic [AW-1:0]  r_wr2;

    logic [CW-1:0]  w_dext;
    logic [AW-1:0]  w_rd;
    logic           w_rd_ok;
    logic           w_hazard;
    logic           w_accept;
    logic           w_out_free;
    logic           w_s1_free;
    logic           w_s2_free;
    logic           w_adv1;
    logic           w_adv2;
    logic [AW-1:0]  n_wr;
    sfd_pkg::t_lane_ctl w_ctl;
    logic signed [SB+18:0] w_left_mix;
    logic signed [SB+18:0] w_right_mix;

    // Configuration port takes every write.
    assign o_cfg_ready = 1'b1;
    assign w_dext      = CW'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= AW'(1);
            r_fb    <= '0;
            r_wet   <= '0;
            r_dry   <= 17'(sfd_pkg::MIX_ONE);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfd_pkg::REG_DELAY: begin
                    if (w_dext == '0) begin
                        r_delay <= AW'(1);
                    end else if (w_dext > CW'(DEPTH - 1)) begin
                        r_delay <= LAST_IX;
                    end else begin
                        r_delay <= AW'(w_dext);
                    end
                end
                sfd_pkg::REG_FEEDBACK: begin
                    if (i_cfg_data[14:0] > 15'(sfd_pkg::FB_MAX)) begin
                        r_fb <= 15'(sfd_pkg::FB_MAX);
                    end else begin
                        r_fb <= i_cfg_data[14:0];
                    end
                end
                sfd_pkg::REG_WET_MIX: begin
                    if (i_cfg_data[15:0] > 16'(sfd_pkg::MIX_ONE)) begin
                        r_wet <= 16'(sfd_pkg::MIX_ONE);
                        r_dry <= '0;
                    end else begin
                        r_wet <= i_cfg_data[15:0];
                        r_dry <= 17'(sfd_pkg::MIX_ONE) - {1'b0, i_cfg_data[15:0]};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Read address, delay samples behind the write pointer, wrapping at the line end.
    assign w_rd = (r_wr >= r_delay) ? (r_wr - r_delay)
                : AW'({1'b0, r_wr} + DEPTH_W - {1'b0, r_delay});
    // Before the first wrap only entries below the pointer have been written.
    assign w_rd_ok = r_wrapped || (w_rd < r_wr);

    // An entry still on its way to the line must not be read.
    assign w_hazard = (r_s1_valid && (w_rd == r_wr1)) || (r_s2_valid && (w_rd == r_wr2));

    // Pipeline flow, from the output back to the input.
    assign w_adv2     = r_s2_valid && w_out_free;
    assign w_s2_free  = !r_s2_valid || w_adv2;
    assign w_adv1     = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_adv1;
    assign o_in_ready = w_s1_free && !w_hazard;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ctl.accept = w_accept;
    assign w_ctl.adv1   = w_adv1;
    assign w_ctl.adv2   = w_adv2;

    assign n_wr = (r_wr == LAST_IX) ? '0 : r_wr + 1'b1;

    // Pointer, fill flag and stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_wrapped  <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_wr <= n_wr;
                if (r_wr == LAST_IX) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv1) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv1) begin
                r_s2_valid <= 1'b1;
            end else if (w_adv2) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // Write addresses travel with their requests.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wr1 <= r_wr;
        end
        if (w_adv1) begin
            r_wr2 <= r_wr1;
        end
    end

    sfd_lane #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_left (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd),
        .i_rd_ok   (w_rd_ok),
        .i_wr_addr (r_wr2),
        .i_x       (i_left_in),
        .i_fb      (r_fb),
        .i_dry     (r_dry),
        .i_wet     (r_wet),
        .o_mix     (w_left_mix)
    );

    sfd_lane #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_right (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd),
        .i_rd_ok   (w_rd_ok),
        .i_wr_addr (r_wr2),
        .i_x       (i_right_in),
        .i_fb      (r_fb),
        .i_dry     (r_dry),
        .i_wet     (r_wet),
        .o_mix     (w_right_mix)
    );

    sfd_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_adv2),
        .i_out_ready (i_out_ready),
        .i_left_mix  (w_left_mix),
        .i_right_mix (w_right_mix),
        .o_out_valid (o_out_valid),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .o_free      (w_out_free)
    );

    // Checks on pointer and pipeline behavior.
    `SFD_ASSERT_RST(a_wr_step, i_clk, i_rst_n, w_accept |=> (r_wr == (($past(r_wr) == LAST_IX) ? '0 : $past(r_wr) + 1'b1)), "write pointer did not advance by one")
    `SFD_ASSERT_RST(a_wrapped_sticky, i_clk, i_rst_n, r_wrapped |=> r_wrapped, "fill flag cleared outside reset")
    `SFD_ASSERT_RST(a_s2_hold, i_clk, i_rst_n, (r_s2_valid && !w_out_free) |=> (r_s2_valid && $stable(r_wr2)), "stalled stage lost its request")
    `SFD_ASSERT(a_wr_gap, i_clk, (i_rst_n && r_s1_valid) |-> (r_wr == ((r_wr1 == LAST_IX) ? '0 : r_wr1 + 1'b1)), "stage one address out of step with pointer")

endmodule
